FILE: hw/rtl/sfp_pkg.sv
// sfp_pkg: shared types and constants for the sync frame parser with timeout
// no dependencies; used by the channel interfaces and the top level
package sfp_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND = 8'h55;
	localparam int         PAYLOAD_LEN = 4;
	localparam int         IDX_W       = $clog2(PAYLOAD_LEN);

	localparam logic [15:0] TIMEOUT_RST  = 16'd300;
	localparam logic [7:0]  MIN_STEP_RST = 8'd5;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic REG_TIMEOUT  = 1'b0;
	localparam logic REG_MIN_STEP = 1'b1;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_POLL = 1'b1;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_SYNC2   = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_CHECK   = 2'd3
	} phase_t;

	typedef struct packed {
		logic        operation;
		logic [7:0]  data_byte;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic               frame_done;
		logic signed [15:0] pan_error;
		logic signed [15:0] tilt_error;
		logic [31:0]        step_ms;
		logic [31:0]        frame_count;
		logic               motors_stop;
	} result_t;

endpackage

FILE: hw/rtl/sfp_item_if.sv
// sfp_item_if: valid/ready channel carrying one input item (byte or poll)
// depends on sfp_pkg
interface sfp_item_if;
	import sfp_pkg::*;

	logic        valid;
	logic        ready;
	logic        operation;
	logic [7:0]  data_byte;
	logic [31:0] now_ms;

	modport source (output valid, operation, data_byte, now_ms, input ready);
	modport sink   (input valid, operation, data_byte, now_ms, output ready);
endinterface

FILE: hw/rtl/sfp_result_if.sv
// sfp_result_if: valid/ready channel carrying one parser result
// depends on sfp_pkg
interface sfp_result_if;
	import sfp_pkg::*;

	logic               valid;
	logic               ready;
	logic               frame_done;
	logic signed [15:0] pan_error;
	logic signed [15:0] tilt_error;
	logic [31:0]        step_ms;
	logic [31:0]        frame_count;
	logic               motors_stop;

	modport source (output valid, frame_done, pan_error, tilt_error, step_ms, frame_count,
		motors_stop, input ready);
	modport sink   (input valid, frame_done, pan_error, tilt_error, step_ms, frame_count,
		motors_stop, output ready);
endinterface

FILE: hw/rtl/sync_frame_parser_xor_timeout.sv
// sync_frame_parser_xor_timeout: 0xAA 0x55 framed parser, xor checksum, frame timeout
// depends on sfp_pkg, sfp_item_if, sfp_result_if
//
//  channel   dir   handshake                    contents
//  items     in    valid/ready                  operation, data_byte, now_ms
//  results   out   valid/ready                  frame_done, pan/tilt, step, count, stop
//  apb       in    psel/penable/pwrite, pready  timeout_ms @0x0, min_step_ms @0x4
//
// one transaction per cycle sustained while results.ready holds high; items pass
// the input register, then the parse/timer logic into the result register
// reset clears the parse phase, counters, timestamps and latched pan/tilt
// a stalled result holds in the result register while the input register
// still takes one more transaction; ready drops only when both are full
module sync_frame_parser_xor_timeout (
	input  logic                      clk,
	input  logic                      arst_n,
	sfp_item_if.sink                  items,
	sfp_result_if.source              results,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [sfp_pkg::ADDR_W-1:0] paddr,
	input  logic [sfp_pkg::DATA_W-1:0] pwdata,
	output logic [sfp_pkg::DATA_W-1:0] prdata,
	output logic                      pready
);
	import sfp_pkg::*;

	logic [15:0] timeout_q;
	logic [7:0]  min_step_q;

	logic        valid_s1;
	item_t       item_s1;
	logic        adv;

	phase_t      phase_q, phase_d;
	logic [7:0]  store_q [PAYLOAD_LEN];
	logic [IDX_W-1:0] idx_q;
	logic [31:0] last_frame_q;
	logic [31:0] last_step_q;
	logic [31:0] good_frames_q;
	logic [15:0] pan_q;
	logic [15:0] tilt_q;

	logic        out_valid_q;
	result_t     res_q;

	logic        is_byte;
	logic [7:0]  sum_c;
	logic        done_c;
	logic [31:0] diff_step;
	logic [31:0] step_c;
	logic [31:0] since_frame;
	logic        stop_c;
	logic [15:0] pan_c;
	logic [15:0] tilt_c;
	logic [31:0] count_c;
	logic        cfg_wr;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RST;
			min_step_q <= MIN_STEP_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_TIMEOUT:  timeout_q  <= pwdata[15:0];
				REG_MIN_STEP: min_step_q <= pwdata[7:0];
				default:      timeout_q  <= timeout_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_TIMEOUT:  prdata = {16'd0, timeout_q};
			REG_MIN_STEP: prdata = {24'd0, min_step_q};
			default:      prdata = '0;
		endcase
	end

	// handshake
	assign adv         = valid_s1 && (!out_valid_q || results.ready);
	assign items.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1.operation <= items.operation;
			item_s1.data_byte <= items.data_byte;
			item_s1.now_ms    <= items.now_ms;
		end
	end

	// parse phase
	assign is_byte = item_s1.operation == OP_BYTE;
	assign sum_c   = store_q[0] ^ store_q[1] ^ store_q[2] ^ store_q[3];

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_HUNT: begin
				if (item_s1.data_byte == SYNC_FIRST) phase_d = PH_SYNC2;
			end
			PH_SYNC2: begin
				if (item_s1.data_byte == SYNC_SECOND) phase_d = PH_PAYLOAD;
				else if (item_s1.data_byte != SYNC_FIRST) phase_d = PH_HUNT;
			end
			PH_PAYLOAD: begin
				if (idx_q == IDX_W'(PAYLOAD_LEN - 1)) phase_d = PH_CHECK;
			end
			PH_CHECK: begin
				if (item_s1.data_byte != sum_c && item_s1.data_byte == SYNC_FIRST)
					phase_d = PH_SYNC2;
				else
					phase_d = PH_HUNT;
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	// frame and timeout datapath
	always_comb begin
		done_c      = is_byte && phase_q == PH_CHECK && item_s1.data_byte == sum_c;
		diff_step   = item_s1.now_ms - last_step_q;
		step_c      = {24'd0, min_step_q};
		if (last_step_q != 32'd0 && item_s1.now_ms > last_step_q
			&& diff_step >= {24'd0, min_step_q})
			step_c = diff_step;
		if (!done_c) step_c = 32'd0;
		since_frame = item_s1.now_ms - last_frame_q;
		stop_c      = !is_byte && since_frame > {16'd0, timeout_q};
		pan_c       = done_c ? {store_q[1], store_q[0]} : pan_q;
		tilt_c      = done_c ? {store_q[3], store_q[2]} : tilt_q;
		count_c     = done_c ? good_frames_q + 32'd1 : good_frames_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			idx_q         <= '0;
			last_frame_q  <= '0;
			last_step_q   <= '0;
			good_frames_q <= '0;
			pan_q         <= '0;
			tilt_q        <= '0;
		end else if (adv && is_byte) begin
			phase_q <= phase_d;
			if (phase_q == PH_SYNC2) idx_q <= '0;
			else if (phase_q == PH_PAYLOAD) idx_q <= idx_q + IDX_W'(1);
			if (done_c) begin
				last_frame_q  <= item_s1.now_ms;
				last_step_q   <= item_s1.now_ms;
				good_frames_q <= count_c;
				pan_q         <= pan_c;
				tilt_q        <= tilt_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_byte && phase_q == PH_PAYLOAD) store_q[idx_q] <= item_s1.data_byte;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.frame_done  <= done_c;
			res_q.pan_error   <= pan_c;
			res_q.tilt_error  <= tilt_c;
			res_q.step_ms     <= step_c;
			res_q.frame_count <= count_c;
			res_q.motors_stop <= stop_c;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.frame_done  = res_q.frame_done;
	assign results.pan_error   = res_q.pan_error;
	assign results.tilt_error  = res_q.tilt_error;
	assign results.step_ms     = res_q.step_ms;
	assign results.frame_count = res_q.frame_count;
	assign results.motors_stop = res_q.motors_stop;

	a_step_zero_without_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.frame_done) |-> results.step_ms == 32'd0)
		else $error("step reported without a frame");

	a_frame_not_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.frame_done) |-> !results.motors_stop)
		else $error("frame and stop in one result");

	a_count_increments: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && done_c) |=> good_frames_q == $past(good_frames_q) + 32'd1)
		else $error("frame count did not advance");

	a_payload_full: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CHECK && $past(phase_q) == PH_PAYLOAD) |-> idx_q == '0)
		else $error("checksum phase entered before four payload bytes");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !results.ready) |=> out_valid_q)
		else $error("stalled result lost");

endmodule

FILE: bench/tb_sync_frame_parser_xor_timeout.sv
// tb_sync_frame_parser_xor_timeout: self-checking bench for the sync frame parser with timeout
// a directed table, then framed random traffic under several register settings, each result checked
// against a fixed value or an in-bench model; depends on sfp_pkg, sfp_item_if, sfp_result_if and the rtl
module tb_sync_frame_parser_xor_timeout;
	timeunit 1ns;
	timeprecision 1ps;
	import sfp_pkg::*;

	localparam int LATENCY     = 2;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 160;
	localparam int PRINT_LIMIT = 40;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_LONG, STALL_TOGGLE} stall_t;

	typedef struct {
		item_t   it;
		bit      fixed;
		result_t exp;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	sfp_item_if   items();
	sfp_result_if results();

	sync_frame_parser_xor_timeout i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// parser model state and its copy of the registers
	phase_t      pr_phase;
	logic [7:0]  pr_payload [PAYLOAD_LEN];
	logic [2:0]  pr_count;
	logic [31:0] pr_last_frame;
	logic [31:0] pr_last_step;
	logic [31:0] pr_frames;
	logic [15:0] pr_pan;
	logic [15:0] pr_tilt;
	logic [15:0] cfg_timeout;
	logic [7:0]  cfg_min_step;

	result_t  awaited_results [$];
	dir_row_t directed_rows [$];
	result_t  head_result;
	int       mismatch_count = 0;
	int       cycle_count    = 0;
	int       items_sent     = 0;
	int       burst_left     = 0;
	logic [31:0] now_cur     = 32'd2000;
	stall_t   stall_mode     = STALL_NONE;
	int       mode_left      = 0;
	int       hold_left      = 0;

	always begin
		#5ns clk = 1'b1;
		#5ns clk = 1'b0;
	end

	function automatic result_t predict_parser_result(item_t it);
		result_t     r;
		logic [7:0]  b;
		logic [7:0]  sum;
		logic [31:0] step;
		logic [31:0] since;
		logic        good;
		r    = '0;
		good = 1'b0;
		step = 32'd0;
		b    = it.data_byte;
		if (it.operation == OP_BYTE) begin
			case (pr_phase)
				PH_HUNT: begin
					if (b == SYNC_FIRST)
						pr_phase = PH_SYNC2;
				end
				PH_SYNC2: begin
					if (b == SYNC_SECOND) begin
						pr_phase = PH_PAYLOAD;
						pr_count = 3'd0;
					end else if (b != SYNC_FIRST) begin
						pr_phase = PH_HUNT;
					end
				end
				PH_PAYLOAD: begin
					pr_payload[pr_count[IDX_W-1:0]] = b;
					pr_count = pr_count + 3'd1;
					if (pr_count == 3'(PAYLOAD_LEN))
						pr_phase = PH_CHECK;
				end
				default: begin
					sum = pr_payload[0] ^ pr_payload[1] ^ pr_payload[2] ^ pr_payload[3];
					if (b == sum) begin
						pr_phase = PH_HUNT;
						good     = 1'b1;
					end else begin
						pr_phase = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
					end
				end
			endcase
			if (good) begin
				pr_pan        = {pr_payload[1], pr_payload[0]};
				pr_tilt       = {pr_payload[3], pr_payload[2]};
				pr_frames     = pr_frames + 32'd1;
				pr_last_frame = it.now_ms;
				step          = {24'd0, cfg_min_step};
				if (pr_last_step != 32'd0 && it.now_ms > pr_last_step)
					step = it.now_ms - pr_last_step;
				if (step < {24'd0, cfg_min_step})
					step = {24'd0, cfg_min_step};
				pr_last_step  = it.now_ms;
			end
		end else begin
			since = it.now_ms - pr_last_frame;
			r.motors_stop = (since > {16'd0, cfg_timeout});
		end
		r.frame_done  = good;
		r.pan_error   = pr_pan;
		r.tilt_error  = pr_tilt;
		r.step_ms     = step;
		r.frame_count = pr_frames;
		return r;
	endfunction

	function automatic result_t fixed_res(logic done, logic [15:0] pan, logic [15:0] tilt,
		logic [31:0] step, logic [31:0] count, logic stop);
		result_t r;
		r.frame_done  = done;
		r.pan_error   = pan;
		r.tilt_error  = tilt;
		r.step_ms     = step;
		r.frame_count = count;
		r.motors_stop = stop;
		return r;
	endfunction

	function automatic void add_row(logic op, logic [7:0] b, logic [31:0] ms, bit fixed,
		result_t exp);
		dir_row_t row;
		row.it.operation = op;
		row.it.data_byte = b;
		row.it.now_ms    = ms;
		row.fixed        = fixed;
		row.exp          = exp;
		directed_rows.push_back(row);
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic send_item(logic op, logic [7:0] b, logic [31:0] ms, bit fixed,
		result_t fixed_exp);
		item_t   it;
		result_t pred;
		it.operation = op;
		it.data_byte = b;
		it.now_ms    = ms;
		if (burst_left == 0) begin
			items.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(40, 200))
				: int'($urandom_range(1, 12));
		end
		burst_left--;
		items.valid     <= 1'b1;
		items.operation <= op;
		items.data_byte <= b;
		items.now_ms    <= ms;
		do @(posedge clk); while (!items.ready);
		pred = predict_parser_result(it);
		awaited_results.push_back(fixed ? fixed_exp : pred);
		items_sent++;
	endtask

	task automatic send_byte(logic [7:0] b);
		case ($urandom_range(0, 63))
			0: now_cur = $urandom;
			1: now_cur = now_cur - $urandom_range(1, 50);
			2: now_cur = 32'd0;
			3: now_cur = now_cur + $urandom_range(100, 70000);
			default: now_cur = now_cur + $urandom_range(0, 3);
		endcase
		send_item(OP_BYTE, b, now_cur, 1'b0, '0);
	endtask

	task automatic apb_access(logic wr, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata,
		output logic [DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [15:0] tmo, logic [7:0] min_step);
		logic [DATA_W-1:0] rd;
		apb_access(1'b1, {REG_TIMEOUT, 2'b00}, {16'd0, tmo}, rd);
		cfg_timeout = tmo;
		apb_access(1'b1, {REG_MIN_STEP, 2'b00}, {24'd0, min_step}, rd);
		cfg_min_step = min_step;
		apb_access(1'b0, {REG_TIMEOUT, 2'b00}, '0, rd);
		if (rd !== {16'd0, tmo})
			report_mismatch($sformatf("timeout_ms read %0h exp %0h", rd, tmo));
		apb_access(1'b0, {REG_MIN_STEP, 2'b00}, '0, rd);
		if (rd !== {24'd0, min_step})
			report_mismatch($sformatf("min_step_ms read %0h exp %0h", rd, min_step));
	endtask

	task automatic wait_idle();
		items.valid <= 1'b0;
		burst_left = 0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic random_traffic(int n);
		int          target;
		int          kind;
		logic [7:0]  pl [PAYLOAD_LEN];
		logic [7:0]  sum;
		logic [7:0]  chk;
		logic [31:0] poll_at;
		target = items_sent + n;
		while (items_sent < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				send_byte(SYNC_FIRST);
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3)) send_byte(SYNC_FIRST);
				send_byte(SYNC_SECOND);
				foreach (pl[i]) begin
					pl[i] = 8'($urandom_range(0, 255));
					send_byte(pl[i]);
				end
				sum = pl[0] ^ pl[1] ^ pl[2] ^ pl[3];
				case ($urandom_range(0, 9))
					0: chk = (sum == SYNC_FIRST) ? 8'h00 : SYNC_FIRST;
					1: chk = sum ^ (8'd1 << $urandom_range(0, 7));
					default: chk = sum;
				endcase
				send_byte(chk);
			end else if (kind < 82) begin
				if ($urandom_range(0, 2) == 0)
					poll_at = $urandom;
				else
					poll_at = pr_last_frame + {16'd0, cfg_timeout} + $urandom_range(0, 4)
						- 32'd2;
				send_item(OP_POLL, 8'($urandom_range(0, 255)), poll_at, 1'b0, '0);
			end else begin
				repeat ($urandom_range(1, 4)) begin
					case ($urandom_range(0, 7))
						0, 1: send_byte(SYNC_FIRST);
						2: send_byte(SYNC_SECOND);
						default: send_byte(8'($urandom_range(0, 255)));
					endcase
				end
			end
		end
	endtask

	// result side stalls on a pattern that changes every so often
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= stall_t'($urandom_range(0, 3));
			mode_left  <= $urandom_range(20, 120);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			STALL_NONE: results.ready <= 1'b1;
			STALL_RANDOM: results.ready <= ($urandom_range(0, 9) >= 3);
			STALL_LONG: begin
				if (hold_left == 0) begin
					results.ready <= !results.ready;
					hold_left <= results.ready ? int'($urandom_range(5, 20))
						: int'($urandom_range(1, 6));
				end else begin
					hold_left <= hold_left - 1;
				end
			end
			default: results.ready <= !results.ready;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result transaction with nothing awaited");
			end else begin
				head_result = awaited_results.pop_front();
				if (results.frame_done !== head_result.frame_done)
					report_mismatch($sformatf("frame_done got %0b exp %0b",
						results.frame_done, head_result.frame_done));
				if (results.pan_error !== head_result.pan_error)
					report_mismatch($sformatf("pan_error got %0d exp %0d",
						results.pan_error, head_result.pan_error));
				if (results.tilt_error !== head_result.tilt_error)
					report_mismatch($sformatf("tilt_error got %0d exp %0d",
						results.tilt_error, head_result.tilt_error));
				if (results.step_ms !== head_result.step_ms)
					report_mismatch($sformatf("step_ms got %0d exp %0d",
						results.step_ms, head_result.step_ms));
				if (results.frame_count !== head_result.frame_count)
					report_mismatch($sformatf("frame_count got %0d exp %0d",
						results.frame_count, head_result.frame_count));
				if (results.motors_stop !== head_result.motors_stop)
					report_mismatch($sformatf("motors_stop got %0b exp %0b",
						results.motors_stop, head_result.motors_stop));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		items.valid     = 1'b0;
		items.operation = OP_BYTE;
		items.data_byte = 8'd0;
		items.now_ms    = 32'd0;
		results.ready   = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		pr_phase        = PH_HUNT;
		foreach (pr_payload[i])
			pr_payload[i] = 8'd0;
		pr_count        = 3'd0;
		pr_last_frame   = 32'd0;
		pr_last_step    = 32'd0;
		pr_frames       = 32'd0;
		pr_pan          = 16'd0;
		pr_tilt         = 16'd0;
		cfg_timeout     = TIMEOUT_RST;
		cfg_min_step    = MIN_STEP_RST;

		// polls at the time extremes and on both sides of the reset timeout
		add_row(OP_POLL, 8'h00, 32'd0, 1'b1, fixed_res(1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 1'b0));
		add_row(OP_POLL, 8'hFF, 32'hFFFF_FFFF, 1'b1,
			fixed_res(1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 1'b1));
		add_row(OP_POLL, 8'h00, 32'd300, 1'b1, fixed_res(1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 1'b0));
		add_row(OP_POLL, 8'h00, 32'd301, 1'b1, fixed_res(1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 1'b1));
		// repeated sync byte, extreme pan and tilt, first frame at time zero
		add_row(OP_BYTE, SYNC_FIRST, 32'd0, 1'b0, '0);
		add_row(OP_BYTE, SYNC_FIRST, 32'd0, 1'b0, '0);
		add_row(OP_BYTE, SYNC_SECOND, 32'd0, 1'b0, '0);
		add_row(OP_BYTE, 8'h00, 32'd0, 1'b0, '0);
		add_row(OP_BYTE, 8'h80, 32'd0, 1'b0, '0);
		add_row(OP_BYTE, 8'hFF, 32'd0, 1'b0, '0);
		add_row(OP_BYTE, 8'h7F, 32'd0, 1'b0, '0);
		add_row(OP_BYTE, 8'h00, 32'd0, 1'b1,
			fixed_res(1'b1, 16'h8000, 16'h7FFF, 32'd5, 32'd1, 1'b0));
		// bad checksum equal to the first sync byte resumes at the second one
		add_row(OP_BYTE, SYNC_FIRST, 32'd1000, 1'b0, '0);
		add_row(OP_BYTE, SYNC_SECOND, 32'd1000, 1'b0, '0);
		add_row(OP_BYTE, 8'h01, 32'd1000, 1'b0, '0);
		add_row(OP_BYTE, 8'h02, 32'd1000, 1'b0, '0);
		add_row(OP_BYTE, 8'h03, 32'd1001, 1'b0, '0);
		add_row(OP_BYTE, 8'h04, 32'd1001, 1'b0, '0);
		add_row(OP_BYTE, SYNC_FIRST, 32'd1001, 1'b0, '0);
		add_row(OP_BYTE, SYNC_SECOND, 32'd1001, 1'b0, '0);
		add_row(OP_BYTE, 8'h10, 32'd1002, 1'b0, '0);
		add_row(OP_BYTE, 8'h20, 32'd1002, 1'b0, '0);
		add_row(OP_BYTE, 8'h30, 32'd1002, 1'b0, '0);
		add_row(OP_BYTE, 8'h40, 32'd1002, 1'b0, '0);
		add_row(OP_BYTE, 8'h40, 32'd1002, 1'b0, '0);
		add_row(OP_POLL, 8'h00, 32'd1302, 1'b0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].it.operation, directed_rows[i].it.data_byte,
				directed_rows[i].it.now_ms, directed_rows[i].fixed, directed_rows[i].exp);
		wait_idle();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: set_config(16'd0, 8'd1);
				1: set_config(16'hFFFF, 8'hFF);
				2: set_config(TIMEOUT_RST, 8'd0);
				default: set_config(16'($urandom), 8'($urandom_range(1, 255)));
			endcase
			random_traffic(PHASE_ITEMS);
			wait_idle();
		end

		repeat (4 * LATENCY) @(posedge clk);
		if (mismatch_count == 0 && awaited_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
